[hdl/texel_format_encoder_macros.svh]
// Assertion macros used by the checker file of the texel format encoder.
`ifndef TEXEL_FORMAT_ENCODER_MACROS_SVH
`define TEXEL_FORMAT_ENCODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TFE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/tfe_pkg.sv]
package tfe_pkg;

  localparam int unsigned TILE_PIXELS = 16;
  localparam int unsigned TILE_IDX_W  = $clog2(TILE_PIXELS);

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam logic [15:0] GREY_WR = 16'd13933;
  localparam logic [15:0] GREY_WG = 16'd46871;
  localparam logic [15:0] GREY_WB = 16'd4732;

  localparam logic [7:0] RGB5A3_OPAQUE_MIN = 8'hE0;

  localparam logic [1:0] OUT_ONE_BYTE  = 2'd1;
  localparam logic [1:0] OUT_TWO_BYTES = 2'd2;

  typedef enum logic [2:0] {
    FMT_I4     = 3'd0,
    FMT_I8     = 3'd1,
    FMT_IA4    = 3'd2,
    FMT_IA8    = 3'd3,
    FMT_RGB565 = 3'd4,
    FMT_RGB5A3 = 3'd5,
    FMT_RGBA8  = 3'd6
  } tfe_fmt_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_READ = 4'b0100,
    S_SEND = 4'b1000
  } tfe_state_e;

  typedef enum logic {
    SEL_PIXEL = 1'b0,
    SEL_STORE = 1'b1
  } tfe_sel_e;

  typedef struct packed {
    logic     capture;
    logic     commit;
    logic     out_load;
    tfe_sel_e out_sel;
    logic     out_last;
    logic     ptr_clr;
    logic     rd_en;
    logic     ptr_inc;
  } tfe_cmd_t;

  typedef struct packed {
    logic has_result;
    logic flush_needed;
    logic out_free;
    logic ptr_last;
  } tfe_status_t;

endpackage

[hdl/texel_format_encoder.sv]
// Texel format encoder: converts RGBA8 pixels, already in tile scan order, into one of the
// texel formats I4, I8, IA4, IA8, RGB565, RGB5A3 or RGBA8 chosen by the format register, and
// writing that register also restarts the I4 pairing and the RGBA8 tile count. Each pixel
// goes through two steps, one to capture it and form the luma products and one to encode it
// into the output register, which waits while the output stage is held up; a new pixel is
// taken only after that. An I4 pixel of even position and a pixel under an unused format
// code give no transfer. In RGBA8 the sixteenth pixel of a tile is followed by a flush of
// the sixteen stored green-blue words, each a registered read of the store, then the load
// of the output register. Single-byte results sit in the low byte of the word.
module texel_format_encoder (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [2:0]                             cfg_wdata_i,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // red [7:0], green [15:8], blue [23:16], alpha [31:24]
  input  logic [tfe_pkg::IN_TDATA_W-1:0]         s_axis_tdata,
  // pad_pixel
  input  logic                                   s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // out_word [15:0], out_bytes [17:16], zero [23:18]
  output logic [tfe_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  output logic                                   m_axis_tlast
);
  import tfe_pkg::*;

  tfe_cmd_t    cmd;
  tfe_status_t status;

  tfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tfe_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_data_i  (s_axis_tdata),
    .pix_pad_i   (s_axis_tuser),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

[hdl/tfe_ctrl.sv]
module tfe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tfe_pkg::tfe_status_t status_i,
  output tfe_pkg::tfe_cmd_t    cmd_o
);
  import tfe_pkg::*;

  tfe_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.out_sel = SEL_PIXEL;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CALC;
        end
      end
      S_CALC: begin
        if (!status_i.has_result) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.commit   = 1'b1;
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = !status_i.flush_needed;
          if (status_i.flush_needed) begin
            cmd_o.ptr_clr = 1'b1;
            state_d       = S_READ;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_SEND;
      end
      S_SEND: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = SEL_STORE;
          cmd_o.out_last = status_i.ptr_last;
          cmd_o.ptr_inc  = 1'b1;
          state_d        = status_i.ptr_last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[hdl/tfe_datapath.sv]
module tfe_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [2:0]                           cfg_wdata_i,
  input  logic [tfe_pkg::IN_TDATA_W-1:0]       pix_data_i,
  input  logic                                 pix_pad_i,
  input  tfe_pkg::tfe_cmd_t                     cmd_i,
  output tfe_pkg::tfe_status_t                  status_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [tfe_pkg::OUT_TDATA_W-1:0]      out_data_o,
  output logic                                 out_last_o
);
  import tfe_pkg::*;

  logic [2:0]            fmt_q;
  logic [3:0]            held_q;
  logic                  odd_q;
  logic [TILE_IDX_W-1:0] count_q;
  logic [TILE_IDX_W-1:0] ptr_q;
  logic                  out_valid_q;

  logic [7:0]  red_q, green_q, blue_q, alpha_q;
  logic        pad_q;
  logic [21:0] prod_r_q;
  logic [23:0] prod_g_q;
  logic [20:0] prod_b_q;

  logic [15:0] store_mem [TILE_PIXELS];
  logic [15:0] rd_data_q;

  logic [15:0] out_word_q;
  logic [1:0]  out_bytes_q;
  logic        out_last_q;

  logic [23:0] grey_sum;
  logic [7:0]  grey;
  logic [15:0] pix_word;
  logic [1:0]  pix_bytes;
  logic        has_result;
  logic        is_rgba8;

  assign grey_sum = {2'b00, prod_r_q} + prod_g_q + {3'b000, prod_b_q};
  assign grey     = grey_sum[23:16];
  assign is_rgba8 = (fmt_q == FMT_RGBA8);

  always_comb begin
    pix_word   = '0;
    pix_bytes  = OUT_TWO_BYTES;
    has_result = 1'b1;
    case (fmt_q)
      FMT_I4: begin
        pix_bytes  = OUT_ONE_BYTE;
        pix_word   = {8'h00, held_q, pad_q ? 4'h0 : grey[7:4]};
        has_result = odd_q;
      end
      FMT_I8: begin
        pix_bytes = OUT_ONE_BYTE;
        pix_word  = {8'h00, grey};
      end
      FMT_IA4: begin
        pix_bytes = OUT_ONE_BYTE;
        pix_word  = {8'h00, alpha_q[7:4], grey[7:4]};
      end
      FMT_IA8: begin
        pix_word = {alpha_q, grey};
      end
      FMT_RGB565: begin
        pix_word = {red_q[7:3], green_q[7:2], blue_q[7:3]};
      end
      FMT_RGB5A3: begin
        if (alpha_q < RGB5A3_OPAQUE_MIN) begin
          pix_word = {1'b0, alpha_q[7:5], red_q[7:4], green_q[7:4], blue_q[7:4]};
        end else begin
          pix_word = {1'b1, red_q[7:3], green_q[7:3], blue_q[7:3]};
        end
      end
      FMT_RGBA8: begin
        pix_word = {alpha_q, red_q};
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
    // In I4 a padding pixel only zeroes its own nibble; the held nibble still goes out.
    if (pad_q && (fmt_q != FMT_I4)) begin
      pix_word = '0;
    end
  end

  assign status_o.has_result   = has_result;
  assign status_o.flush_needed = is_rgba8 && (count_q == TILE_IDX_W'(TILE_PIXELS - 1));
  assign status_o.out_free     = !out_valid_q || out_ready_i;
  assign status_o.ptr_last     = (ptr_q == TILE_IDX_W'(TILE_PIXELS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       <= FMT_I4;
      held_q      <= '0;
      odd_q       <= 1'b0;
      count_q     <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fmt_q   <= cfg_wdata_i;
        held_q  <= '0;
        odd_q   <= 1'b0;
        count_q <= '0;
      end else if (cmd_i.commit) begin
        if (fmt_q == FMT_I4) begin
          if (!odd_q) begin
            held_q <= pad_q ? 4'h0 : grey[7:4];
          end
          odd_q <= !odd_q;
        end
        if (is_rgba8) begin
          count_q <= count_q + 1'b1;
        end
      end
      if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      red_q    <= pix_data_i[7:0];
      green_q  <= pix_data_i[15:8];
      blue_q   <= pix_data_i[23:16];
      alpha_q  <= pix_data_i[31:24];
      pad_q    <= pix_pad_i;
      prod_r_q <= 22'(pix_data_i[7:0]) * GREY_WR;
      prod_g_q <= 24'(pix_data_i[15:8]) * GREY_WG;
      prod_b_q <= 21'(pix_data_i[23:16]) * GREY_WB;
    end
    if (cmd_i.out_load) begin
      out_last_q <= cmd_i.out_last;
      if (cmd_i.out_sel == SEL_STORE) begin
        out_word_q  <= rd_data_q;
        out_bytes_q <= OUT_TWO_BYTES;
      end else begin
        out_word_q  <= pix_word;
        out_bytes_q <= pix_bytes;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && is_rgba8) begin
      store_mem[count_q] <= pad_q ? 16'h0000 : {green_q, blue_q};
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= store_mem[ptr_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {6'b000000, out_bytes_q, out_word_q};
  assign out_last_o  = out_last_q;

endmodule

[hdl/tfe_checker.sv]
`include "texel_format_encoder_macros.svh"

module tfe_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [tfe_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input logic                               m_axis_tlast
);
  import tfe_pkg::*;

  `TFE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "Stalled output transfer changed.")
  `TFE_ASSERT_SAME(a_byte_count, m_axis_tvalid, m_axis_tdata[17:16] == OUT_ONE_BYTE || m_axis_tdata[17:16] == OUT_TWO_BYTES, "Byte count out of range.")
  `TFE_ASSERT_SAME(a_single_byte_low, m_axis_tvalid && m_axis_tdata[17:16] == OUT_ONE_BYTE, m_axis_tdata[15:8] == 8'h00, "Single byte result has a non-zero high byte.")
  `TFE_ASSERT_NEXT(a_one_pixel_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "A second pixel was taken while one was being encoded.")

endmodule

bind texel_format_encoder tfe_checker u_tfe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

[tb/tb_texel_format_encoder.sv]
`timescale 1ns / 1ps

module tb_texel_format_encoder;
  import tfe_pkg::*;

  localparam logic [2:0] FMT_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_DIR = 24;
  localparam int NUM_PHASES = 11;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       pad;
  } pixel_t;

  typedef struct {
    logic [15:0] word;
    logic [1:0]  nbytes;
    logic        last;
  } texel_t;

  typedef struct packed {
    logic [2:0]  fmt;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        pad;
    logic        typed;
    logic [15:0] word;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_wdata_i = 3'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  texel_t texel_q[$];
  int     mismatch_count = 0;
  int     cycle_count = 0;
  int     src_idle = 0;
  int     sink_stall = 0;
  logic   hold_go = 1'b0;
  logic   hold_rx = 1'b0;

  logic [2:0]  pred_fmt = FMT_I4;
  logic [3:0]  pred_held = '0;
  logic        pred_odd = 1'b0;
  logic [3:0]  pred_count = '0;
  logic [15:0] pred_gb [TILE_PIXELS];

  dir_row_t dir_rows [NUM_DIR] = '{
    '{FMT_I4,     8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0, 1'b0, 16'h0000},
    '{FMT_I4,     8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 16'h00F0},
    '{FMT_I4,     8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1, 1'b0, 16'h0000},
    '{FMT_I4,     8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0, 1'b1, 16'h000F},
    '{FMT_I4,     8'd200, 8'd100, 8'd50, 8'h00, 1'b0, 1'b0, 16'h0000},
    '{FMT_I4,     8'd17, 8'd34, 8'd51, 8'h00, 1'b0, 1'b0, 16'h0000},
    '{FMT_I8,     8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 16'h00FF},
    '{FMT_I8,     8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 16'h0000},
    '{FMT_I8,     8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 16'h0000},
    '{FMT_I8,     8'd90, 8'd180, 8'd30, 8'h00, 1'b0, 1'b0, 16'h0000},
    '{FMT_IA4,    8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 16'h00FF},
    '{FMT_IA4,    8'd10, 8'd200, 8'd100, 8'h5A, 1'b0, 1'b0, 16'h0000},
    '{FMT_IA8,    8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 16'hFFFF},
    '{FMT_IA8,    8'd60, 8'd70, 8'd80, 8'h81, 1'b0, 1'b0, 16'h0000},
    '{FMT_RGB565, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0, 1'b1, 16'hFFFF},
    '{FMT_RGB565, 8'h07, 8'h03, 8'h07, 8'h00, 1'b0, 1'b1, 16'h0000},
    '{FMT_RGB565, 8'h55, 8'hAA, 8'h33, 8'h00, 1'b0, 1'b0, 16'h0000},
    '{FMT_RGB5A3, 8'hFF, 8'hFF, 8'hFF, 8'hE0, 1'b0, 1'b1, 16'hFFFF},
    '{FMT_RGB5A3, 8'hFF, 8'hFF, 8'hFF, 8'hDF, 1'b0, 1'b1, 16'h6FFF},
    '{FMT_RGB5A3, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 16'h0000},
    '{FMT_RGB5A3, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 16'h0000},
    '{FMT_RGBA8,  8'h12, 8'h34, 8'h56, 8'h78, 1'b0, 1'b0, 16'h0000},
    '{FMT_RGBA8,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 16'h0000},
    '{FMT_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 16'h0000}
  };

  logic [2:0] phase_fmt [NUM_PHASES] = '{
    FMT_RGBA8, FMT_I4, FMT_I8, FMT_IA4, FMT_IA8, FMT_RGB565,
    FMT_RGB5A3, FMT_UNUSED, FMT_RGBA8, FMT_I4, FMT_RGB5A3
  };

  texel_format_encoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [7:0] luma(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned sum;
    sum = 13933 * r + 46871 * g + 4732 * b;
    return sum[23:16];
  endfunction

  task automatic push_texel(logic [15:0] word, logic [1:0] nbytes, logic last);
    texel_t t;
    t.word = word;
    t.nbytes = nbytes;
    t.last = last;
    texel_q.push_back(t);
  endtask

  task automatic encode_pixel(pixel_t p, logic typed, logic [15:0] typed_word);
    logic [7:0]  grey;
    logic [15:0] w;
    logic [1:0]  nb;
    logic        single;
    grey = luma(p.red, p.green, p.blue);
    single = 1'b1;
    nb = OUT_TWO_BYTES;
    w = '0;
    case (pred_fmt)
      FMT_I4: begin
        if (!pred_odd) begin
          pred_held = p.pad ? 4'h0 : grey[7:4];
          pred_odd = 1'b1;
          single = 1'b0;
        end else begin
          w = {8'h00, pred_held, (p.pad ? 4'h0 : grey[7:4])};
          pred_odd = 1'b0;
          nb = OUT_ONE_BYTE;
        end
      end
      FMT_I8: begin
        w = {8'h00, grey};
        nb = OUT_ONE_BYTE;
      end
      FMT_IA4: begin
        w = {8'h00, p.alpha[7:4], grey[7:4]};
        nb = OUT_ONE_BYTE;
      end
      FMT_IA8: w = {p.alpha, grey};
      FMT_RGB565: w = {p.red[7:3], p.green[7:2], p.blue[7:3]};
      FMT_RGB5A3: begin
        if (p.alpha < RGB5A3_OPAQUE_MIN) begin
          w = {1'b0, p.alpha[7:5], p.red[7:4], p.green[7:4], p.blue[7:4]};
        end else begin
          w = {1'b1, p.red[7:3], p.green[7:3], p.blue[7:3]};
        end
      end
      FMT_RGBA8: begin
        single = 1'b0;
        push_texel(p.pad ? 16'h0000 : {p.alpha, p.red}, OUT_TWO_BYTES, pred_count != 4'd15);
        pred_gb[pred_count] = p.pad ? 16'h0000 : {p.green, p.blue};
        if (pred_count == 4'd15) begin
          for (int i = 0; i < TILE_PIXELS; i++) begin
            push_texel(pred_gb[i], OUT_TWO_BYTES, i == TILE_PIXELS - 1);
          end
        end
        pred_count = pred_count + 4'd1;
      end
      default: single = 1'b0;
    endcase
    if (single) begin
      if (p.pad && (pred_fmt != FMT_I4)) begin
        w = '0;
      end
      push_texel(typed ? typed_word : w, nb, 1'b1);
    end
  endtask

  task automatic check_texel();
    texel_t e;
    if (texel_q.size() == 0) begin
      $display("%0t: unexpected transfer, actual word %h bytes %0d last %b", $time,
               m_axis_tdata[15:0], m_axis_tdata[17:16], m_axis_tlast);
      mismatch_count++;
    end else begin
      e = texel_q.pop_front();
      if (m_axis_tdata[15:0] !== e.word) begin
        $display("%0t: out_word expected %h actual %h", $time, e.word, m_axis_tdata[15:0]);
        mismatch_count++;
      end
      if (m_axis_tdata[17:16] !== e.nbytes) begin
        $display("%0t: out_bytes expected %0d actual %0d", $time, e.nbytes,
                 m_axis_tdata[17:16]);
        mismatch_count++;
      end
      if (m_axis_tlast !== e.last) begin
        $display("%0t: last_of_run expected %b actual %b", $time, e.last, m_axis_tlast);
        mismatch_count++;
      end
      if (m_axis_tdata[23:18] !== 6'd0) begin
        $display("%0t: tdata padding expected 00 actual %h", $time, m_axis_tdata[23:18]);
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      check_texel();
    end
    m_axis_tready <= !hold_rx && ($urandom_range(99) >= sink_stall);
  end

  // The receiver holds off for a long stretch so that the output stage and then the input fill.
  initial begin
    do @(posedge clk_i); while (!hold_go);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[texel_format_encoder] ERROR");
      $finish;
    end
  end

  task automatic send_pixel(pixel_t p, logic typed, logic [15:0] typed_word);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {p.alpha, p.blue, p.green, p.red};
    s_axis_tuser <= p.pad;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    encode_pixel(p, typed, typed_word);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (texel_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_format(logic [2:0] fmt);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= fmt;
    pred_fmt = fmt;
    pred_held = '0;
    pred_odd = 1'b0;
    pred_count = '0;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] rand_channel();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.red = rand_channel();
    p.green = rand_channel();
    p.blue = rand_channel();
    p.alpha = ($urandom_range(3) == 0) ? 8'($urandom_range(8'hD8, 8'hE8)) : rand_channel();
    p.pad = ($urandom_range(7) == 0);
    return p;
  endfunction

  initial begin
    pixel_t p;
    int     n_items;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIR; i++) begin
      if (dir_rows[i].fmt != pred_fmt) begin
        set_format(dir_rows[i].fmt);
      end
      p = '{dir_rows[i].red, dir_rows[i].green, dir_rows[i].blue, dir_rows[i].alpha,
            dir_rows[i].pad};
      send_pixel(p, dir_rows[i].typed, dir_rows[i].word);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_format(phase_fmt[ph]);
      case (ph % 4)
        0: begin src_idle = 0;  sink_stall = 0;  end
        1: begin src_idle = 46; sink_stall = 0;  end
        2: begin src_idle = 0;  sink_stall = 46; end
        default: begin src_idle = 34; sink_stall = 34; end
      endcase
      if (phase_fmt[ph] == FMT_RGBA8) begin
        n_items = 48;
      end else if (phase_fmt[ph] == FMT_UNUSED) begin
        n_items = 8;
      end else begin
        n_items = 18;
      end
      if (ph == 8) begin
        hold_go <= 1'b1;
      end
      for (int k = 0; k < n_items; k++) begin
        send_pixel(rand_pixel(), 1'b0, 16'h0000);
      end
    end

    drain();
    if (mismatch_count == 0) begin
      $display("[texel_format_encoder] OK");
    end else begin
      $display("[texel_format_encoder] ERROR");
    end
    $finish;
  end

endmodule
